// ===== hw/rtl/bresenham_line_rasterizer_core_macros.svh =====
// Assertion macros shared by the line rasterizer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define BLR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("line rasterizer assertion failed");
// When the trigger holds, the outcome must hold at the following clock edge.
`define BLR_ASSERT_NEXT(lbl, clk, rst_n, trig, outcome) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (outcome)) \
    else $error("line rasterizer assertion failed");
`else
`define BLR_ASSERT(lbl, clk, rst_n, prop)
`define BLR_ASSERT_NEXT(lbl, clk, rst_n, trig, outcome)
`endif

`endif

// ===== hw/rtl/blr_pkg.sv =====
// Shared types and constants for the midpoint line rasterizer.
// No dependencies; used by blr_setup, blr_step and the top level.
`timescale 1ns / 1ps
`default_nettype none

package blr_pkg;

  // Width of the gray value carried with each pixel.
  localparam int unsigned InkW = 8;

  // Extra bits of the decision value over the coordinate width.
  localparam int unsigned DecExtraBits = 4;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_e;

  // Orientation of the line being scanned.
  typedef struct packed {
    logic major_is_y;
    logic slope_down;
  } dir_t;

endpackage

`default_nettype wire

// ===== hw/rtl/blr_setup.sv =====
// Line setup: picks the major axis, orders the endpoints and derives the
// initial decision value and its increments. Depends on blr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blr_setup #(
  parameter int unsigned CoordW = 12,
  parameter int unsigned DecW   = 16
) (
  input  wire logic [CoordW-1:0]      start_x_i,
  input  wire logic [CoordW-1:0]      start_y_i,
  input  wire logic [CoordW-1:0]      end_x_i,
  input  wire logic [CoordW-1:0]      end_y_i,
  output logic      [CoordW-1:0]      a0_o,
  output logic      [CoordW-1:0]      b0_o,
  output logic      [CoordW-1:0]      a1_o,
  output blr_pkg::dir_t               dir_o,
  output logic signed [DecW-1:0]      decision_o,
  output logic signed [DecW-1:0]      step_straight_o,
  output logic signed [DecW-1:0]      step_up_diag_o,
  output logic signed [DecW-1:0]      step_down_diag_o
);

  localparam int unsigned DiffW = CoordW + 1;

  logic signed [DiffW-1:0]  dx, dy, dmin;
  logic        [DiffW-1:0]  adx, ady;
  logic                     major_x, swap;
  logic        [CoordW-1:0] pa0, pb0, pa1, pb1, b1, dmaj;
  logic signed [DecW-1:0]   dmin_w, dmaj_w, dmin2, dmaj2;

  assign dx = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
  assign dy = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
  assign adx = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
  assign ady = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);

  // Comparing magnitudes is the same as comparing squares; ties go to Y.
  assign major_x = (adx > ady);

  assign pa0 = major_x ? start_x_i : start_y_i;
  assign pb0 = major_x ? start_y_i : start_x_i;
  assign pa1 = major_x ? end_x_i   : end_y_i;
  assign pb1 = major_x ? end_y_i   : end_x_i;

  // Scan always runs upward along the major axis.
  assign swap = (pa1 < pa0);
  assign a0_o = swap ? pa1 : pa0;
  assign b0_o = swap ? pb1 : pb0;
  assign a1_o = swap ? pa0 : pa1;
  assign b1   = swap ? pb0 : pb1;

  assign dmaj = a1_o - a0_o;
  assign dmin = $signed({1'b0, b1}) - $signed({1'b0, b0_o});

  assign dmaj_w = $signed({{(DecW-CoordW){1'b0}}, dmaj});
  assign dmin_w = $signed({{(DecW-DiffW){dmin[DiffW-1]}}, dmin});
  assign dmin2  = dmin_w <<< 1;
  assign dmaj2  = dmaj_w <<< 1;

  assign dir_o.major_is_y = ~major_x;
  assign dir_o.slope_down = dmin[DiffW-1];

  assign decision_o       = dmin[DiffW-1] ? (dmin2 + dmaj_w) : (dmin2 - dmaj_w);
  assign step_straight_o  = dmin2;
  assign step_up_diag_o   = dmin2 - dmaj2;
  assign step_down_diag_o = dmin2 + dmaj2;

endmodule

`default_nettype wire

// ===== hw/rtl/blr_step.sv =====
// One midpoint step: updates the decision value and moves to the next pixel.
// Depends on blr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blr_step #(
  parameter int unsigned CoordW = 12,
  parameter int unsigned DecW   = 16
) (
  input  wire logic [CoordW-1:0]        cur_a_i,
  input  wire logic [CoordW-1:0]        cur_b_i,
  input  wire blr_pkg::dir_t            dir_i,
  input  wire logic signed [DecW-1:0]   decision_i,
  input  wire logic signed [DecW-1:0]   step_straight_i,
  input  wire logic signed [DecW-1:0]   step_up_diag_i,
  input  wire logic signed [DecW-1:0]   step_down_diag_i,
  output logic      [CoordW-1:0]        next_a_o,
  output logic      [CoordW-1:0]        next_b_o,
  output logic signed [DecW-1:0]        next_decision_o
);

  logic not_pos;

  assign not_pos = decision_i[DecW-1] | (decision_i == '0);

  always_comb begin
    next_b_o        = cur_b_i;
    next_decision_o = decision_i;
    // A zero decision moves straight on a rising slope, diagonally on a falling one.
    if (!dir_i.slope_down) begin
      if (not_pos) begin
        next_decision_o = decision_i + step_straight_i;
      end else begin
        next_decision_o = decision_i + step_up_diag_i;
        next_b_o        = cur_b_i + CoordW'(1);
      end
    end else begin
      if (not_pos) begin
        next_decision_o = decision_i + step_down_diag_i;
        next_b_o        = cur_b_i - CoordW'(1);
      end else begin
        next_decision_o = decision_i + step_straight_i;
      end
    end
  end

  assign next_a_o = cur_a_i + CoordW'(1);

endmodule

`default_nettype wire

// ===== hw/rtl/bresenham_line_rasterizer_core.sv =====
// Midpoint line rasterizer producing one pixel per cycle while the result side is not stalled.
// Depends on blr_pkg, blr_setup, blr_step and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "bresenham_line_rasterizer_core_macros.svh"

// A start request (mode 0) carries two endpoints and a gray value and yields
// the line's first pixel; each step request (mode 1) yields the next pixel,
// with last_pixel_o set on the final endpoint. Step requests with no line in
// progress give no result, and a start request drops any line in progress.
// The block takes one request per cycle while in_ready_o is high: each request
// passes an input register, then the setup or step logic, then the result
// register, which loads only when it is empty or its pixel is being taken.
// in_ready_o falls only when both registers are full and the result is not
// being taken.

module bresenham_line_rasterizer_core #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        mode_i,
  input  wire logic [COORD_BITS-1:0]       start_x_i,
  input  wire logic [COORD_BITS-1:0]       start_y_i,
  input  wire logic [COORD_BITS-1:0]       end_x_i,
  input  wire logic [COORD_BITS-1:0]       end_y_i,
  input  wire logic [blr_pkg::InkW-1:0]    ink_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [COORD_BITS-1:0]       pixel_x_o,
  output logic      [COORD_BITS-1:0]       pixel_y_o,
  output logic      [blr_pkg::InkW-1:0]    pixel_value_o,
  output logic                             last_pixel_o
);

  localparam int unsigned DecW = COORD_BITS + blr_pkg::DecExtraBits;

  // Input register.
  logic                        in_valid_q;
  blr_pkg::mode_e              mode_q;
  logic [COORD_BITS-1:0]       start_x_q, start_y_q, end_x_q, end_y_q;
  logic [blr_pkg::InkW-1:0]    ink_q;

  // Line state.
  logic                        line_active_q, line_active_d;
  logic [COORD_BITS-1:0]       cur_a_q, cur_b_q, major_end_q;
  blr_pkg::dir_t               dir_q;
  logic signed [DecW-1:0]      decision_q, step_straight_q, step_up_diag_q, step_down_diag_q;
  logic [blr_pkg::InkW-1:0]    held_ink_q;

  // Result register.
  logic                        out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0]       pixel_x_q, pixel_x_d, pixel_y_q, pixel_y_d;
  logic [blr_pkg::InkW-1:0]    pixel_value_q;
  logic                        last_pixel_q;

  // Setup and step results.
  logic [COORD_BITS-1:0]       su_a0, su_b0, su_a1;
  blr_pkg::dir_t               su_dir;
  logic signed [DecW-1:0]      su_decision, su_straight, su_up, su_down;
  logic [COORD_BITS-1:0]       st_a, st_b;
  logic signed [DecW-1:0]      st_decision;

  // Next line state.
  logic [COORD_BITS-1:0]       next_a, next_b, next_end;
  blr_pkg::dir_t               next_dir;
  logic signed [DecW-1:0]      next_decision, next_straight, next_up, next_down;
  logic [blr_pkg::InkW-1:0]    next_ink;
  logic                        fin;

  logic is_start, out_free, advance, produces, load_state;

  assign is_start   = (mode_q == blr_pkg::MODE_START);
  assign out_free   = ~out_valid_q | out_ready_i;
  assign advance    = in_valid_q & out_free;
  assign produces   = is_start | line_active_q;
  assign load_state = advance & produces;
  assign in_ready_o = ~in_valid_q | advance;

  blr_setup #(
    .CoordW (COORD_BITS),
    .DecW   (DecW)
  ) u_setup (
    .start_x_i        (start_x_q),
    .start_y_i        (start_y_q),
    .end_x_i          (end_x_q),
    .end_y_i          (end_y_q),
    .a0_o             (su_a0),
    .b0_o             (su_b0),
    .a1_o             (su_a1),
    .dir_o            (su_dir),
    .decision_o       (su_decision),
    .step_straight_o  (su_straight),
    .step_up_diag_o   (su_up),
    .step_down_diag_o (su_down)
  );

  blr_step #(
    .CoordW (COORD_BITS),
    .DecW   (DecW)
  ) u_step (
    .cur_a_i          (cur_a_q),
    .cur_b_i          (cur_b_q),
    .dir_i            (dir_q),
    .decision_i       (decision_q),
    .step_straight_i  (step_straight_q),
    .step_up_diag_i   (step_up_diag_q),
    .step_down_diag_i (step_down_diag_q),
    .next_a_o         (st_a),
    .next_b_o         (st_b),
    .next_decision_o  (st_decision)
  );

  always_comb begin
    if (is_start) begin
      next_a        = su_a0;
      next_b        = su_b0;
      next_end      = su_a1;
      next_dir      = su_dir;
      next_decision = su_decision;
      next_straight = su_straight;
      next_up       = su_up;
      next_down     = su_down;
      next_ink      = ink_q;
    end else begin
      next_a        = st_a;
      next_b        = st_b;
      next_end      = major_end_q;
      next_dir      = dir_q;
      next_decision = st_decision;
      next_straight = step_straight_q;
      next_up       = step_up_diag_q;
      next_down     = step_down_diag_q;
      next_ink      = held_ink_q;
    end
    fin       = (next_a == next_end);
    pixel_x_d = next_dir.major_is_y ? next_b : next_a;
    pixel_y_d = next_dir.major_is_y ? next_a : next_b;
  end

  always_comb begin
    line_active_d = line_active_q;
    if (load_state) begin
      line_active_d = ~fin;
    end
    out_valid_d = out_valid_q & ~out_ready_i;
    if (load_state) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      line_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      line_active_q <= line_active_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q    <= blr_pkg::mode_e'(mode_i);
      start_x_q <= start_x_i;
      start_y_q <= start_y_i;
      end_x_q   <= end_x_i;
      end_y_q   <= end_y_i;
      ink_q     <= ink_i;
    end
    if (load_state) begin
      cur_a_q          <= next_a;
      cur_b_q          <= next_b;
      major_end_q      <= next_end;
      dir_q            <= next_dir;
      decision_q       <= next_decision;
      step_straight_q  <= next_straight;
      step_up_diag_q   <= next_up;
      step_down_diag_q <= next_down;
      held_ink_q       <= next_ink;
      pixel_x_q        <= pixel_x_d;
      pixel_y_q        <= pixel_y_d;
      pixel_value_q    <= next_ink;
      last_pixel_q     <= fin;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pixel_x_q;
  assign pixel_y_o     = pixel_y_q;
  assign pixel_value_o = pixel_value_q;
  assign last_pixel_o  = last_pixel_q;

  `BLR_ASSERT_NEXT(a_last_ends_line, clk_i, rst_ni, load_state && fin, !line_active_q)
  `BLR_ASSERT(a_scan_within_line, clk_i, rst_ni, !line_active_q || (cur_a_q < major_end_q))
  `BLR_ASSERT_NEXT(a_idle_step_silent, clk_i, rst_ni, advance && !produces, !out_valid_q)
  `BLR_ASSERT(a_result_from_request, clk_i, rst_ni, !$rose(out_valid_q) || $past(load_state))

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for bresenham_line_rasterizer_core.
// Depends on blr_pkg and the rasterizer RTL; a line tracker class predicts
// every pixel and checks the pixels that the block hands out.
`timescale 1ns / 1ps

module tb;

  localparam int CW = 12;
  localparam int DW = CW + blr_pkg::DecExtraBits;
  localparam int MaxCoord = (1 << CW) - 1;
  localparam int ItemTarget = 1550;

  typedef struct packed {
    logic [CW-1:0]            x;
    logic [CW-1:0]            y;
    logic [blr_pkg::InkW-1:0] gray;
    logic                     fin;
  } pixel_t;

  // Follows the line in progress and holds the pixels still owed by the block.
  class line_tracker;
    bit                       active;
    bit                       major_y;
    bit                       falling;
    logic [CW-1:0]            cur_major;
    logic [CW-1:0]            cur_minor;
    logic [CW-1:0]            major_stop;
    logic signed [DW-1:0]     decision;
    logic signed [DW-1:0]     inc_straight;
    logic signed [DW-1:0]     inc_up;
    logic signed [DW-1:0]     inc_down;
    logic [blr_pkg::InkW-1:0] gray;
    pixel_t                   pending_pixels[$];
    int                       mismatches;
    int                       pixels_seen;

    function new();
      active = 0;
      major_y = 0;
      falling = 0;
      cur_major = '0;
      cur_minor = '0;
      major_stop = '0;
      decision = '0;
      inc_straight = '0;
      inc_up = '0;
      inc_down = '0;
      gray = '0;
      mismatches = 0;
      pixels_seen = 0;
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Returns 1 when the request yields a pixel.
    function bit take_request(blr_pkg::mode_e mode, logic [CW-1:0] sx, logic [CW-1:0] sy,
                              logic [CW-1:0] ex, logic [CW-1:0] ey,
                              logic [blr_pkg::InkW-1:0] ink);
      int x0, y0, x1, y1, dx, dy, a0, b0, a1, b1, dmaj, dmin, t;
      pixel_t px;
      if (mode == blr_pkg::MODE_START) begin
        x0 = int'(sx);
        y0 = int'(sy);
        x1 = int'(ex);
        y1 = int'(ey);
        dx = x1 - x0;
        dy = y1 - y0;
        if (dx * dx > dy * dy) begin
          major_y = 0;
          a0 = x0; b0 = y0; a1 = x1; b1 = y1;
        end else begin
          major_y = 1;
          a0 = y0; b0 = x0; a1 = y1; b1 = x1;
        end
        if (a1 < a0) begin
          t = a0; a0 = a1; a1 = t;
          t = b0; b0 = b1; b1 = t;
        end
        dmaj = a1 - a0;
        dmin = b1 - b0;
        falling = (dmin < 0);
        decision = DW'(falling ? (2 * dmin + dmaj) : (2 * dmin - dmaj));
        inc_straight = DW'(2 * dmin);
        inc_up = DW'(2 * (dmin - dmaj));
        inc_down = DW'(2 * (dmin + dmaj));
        cur_major = a0[CW-1:0];
        cur_minor = b0[CW-1:0];
        major_stop = a1[CW-1:0];
        gray = ink;
        active = 1;
      end else begin
        if (!active) return 0;
        // At a zero decision a rising line goes straight, a falling one steps down.
        if (!falling) begin
          if (decision <= 0) begin
            decision = decision + inc_straight;
          end else begin
            decision = decision + inc_up;
            cur_minor = cur_minor + 1'b1;
          end
        end else begin
          if (decision <= 0) begin
            decision = decision + inc_down;
            cur_minor = cur_minor - 1'b1;
          end else begin
            decision = decision + inc_straight;
          end
        end
        cur_major = cur_major + 1'b1;
      end
      px.fin = (cur_major == major_stop);
      px.x = major_y ? cur_minor : cur_major;
      px.y = major_y ? cur_major : cur_minor;
      px.gray = gray;
      if (px.fin) active = 0;
      pending_pixels = {pending_pixels, px};
      return 1;
    endfunction

    task check_pixel(logic [CW-1:0] x, logic [CW-1:0] y, logic [blr_pkg::InkW-1:0] g,
                     logic fin);
      pixel_t want;
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected pixel (%0d,%0d)", x, y));
      end else begin
        want = pending_pixels.pop_front();
        if (x !== want.x) report($sformatf("pixel_x %0d, want %0d", x, want.x));
        if (y !== want.y) report($sformatf("pixel_y %0d, want %0d", y, want.y));
        if (g !== want.gray) report($sformatf("pixel_value %0d, want %0d", g, want.gray));
        if (fin !== want.fin) report($sformatf("last_pixel %0b, want %0b", fin, want.fin));
      end
    endtask

    function int owed();
      return pending_pixels.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     mode_i;
  logic [CW-1:0]            start_x_i;
  logic [CW-1:0]            start_y_i;
  logic [CW-1:0]            end_x_i;
  logic [CW-1:0]            end_y_i;
  logic [blr_pkg::InkW-1:0] ink_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [CW-1:0]            pixel_x_o;
  logic [CW-1:0]            pixel_y_o;
  logic [blr_pkg::InkW-1:0] pixel_value_o;
  logic                     last_pixel_o;

  line_tracker lines = new();
  int items_counted = 0;
  bit sender_calm = 0;

  bresenham_line_rasterizer_core #(
    .COORD_BITS(CW)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .ink_i        (ink_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_value_o(pixel_value_o),
    .last_pixel_o (last_pixel_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAIL bresenham_line_rasterizer_core");
    $finish;
  end

  // Mostly no gap, sometimes a short one, now and then a long one; none when calm.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return MaxCoord;
    return $urandom_range(0, MaxCoord);
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > MaxCoord) return MaxCoord;
    return v;
  endfunction

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic send_request(blr_pkg::mode_e mode, logic [CW-1:0] sx, logic [CW-1:0] sy,
                              logic [CW-1:0] ex, logic [CW-1:0] ey,
                              logic [blr_pkg::InkW-1:0] ink);
    int gap;
    gap = pick_gap(sender_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    start_x_i <= sx;
    start_y_i <= sy;
    end_x_i <= ex;
    end_y_i <= ey;
    ink_i <= ink;
    do @(posedge clk_i); while (!in_ready_o);
    void'(lines.take_request(mode, sx, sy, ex, ey, ink));
    items_counted++;
  endtask

  // A start request and a number of step requests; the steps carry junk endpoints.
  task automatic draw_line(int sx, int sy, int ex, int ey, logic [blr_pkg::InkW-1:0] ink,
                           int nsteps);
    send_request(blr_pkg::MODE_START, sx[CW-1:0], sy[CW-1:0], ex[CW-1:0], ey[CW-1:0], ink);
    repeat (nsteps) begin
      send_request(blr_pkg::MODE_STEP, CW'($urandom), CW'($urandom), CW'($urandom),
                   CW'($urandom), blr_pkg::InkW'($urandom));
    end
  endtask

  // Withdraws the request that was just taken, then waits for every owed pixel.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lines.owed() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      lines.check_pixel(pixel_x_o, pixel_y_o, pixel_value_o, last_pixel_o);
    end
  end

  // Result side: random bursts and stalls, plus two long hold-offs that back
  // the block up while requests keep coming.
  initial begin : receiver
    int run, hold, holds_done, runs;
    bit calm;
    holds_done = 0;
    runs = 0;
    calm = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (holds_done < 2 && lines.pixels_seen >= (holds_done == 0 ? 250 : 900)) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (150) @(negedge clk_i);
        holds_done++;
      end
      if (runs % 30 == 0) calm = ($urandom_range(0, 4) == 0);
      runs++;
      run = $urandom_range(1, 40);
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat (run - 1) @(negedge clk_i);
      hold = pick_gap(calm);
      if (hold > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (hold - 1) @(negedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int r, sx, sy, ex, ey, len, dmin, da, db, nsteps;
    bit paused;
    paused = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = blr_pkg::MODE_START;
    start_x_i = '0;
    start_y_i = '0;
    end_x_i = '0;
    end_y_i = '0;
    ink_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // A step with no line in progress gives nothing.
    send_request(blr_pkg::MODE_STEP, '1, '0, '1, '0, 8'hFF);
    // Equal endpoints make one final pixel; the step after it is ignored.
    draw_line(5, 5, 5, 5, 8'hFF, 1);
    // Full-width horizontal line, dropped by the next start.
    draw_line(0, 0, MaxCoord, 0, 8'h00, 2);
    // Endpoints given against the scan direction on a shallow rising line.
    draw_line(MaxCoord, MaxCoord, MaxCoord - 3, MaxCoord - 1, 8'hA5, 3);
    // Falling slope with X major, abandoned before its end.
    draw_line(10, 0, 0, 3, 8'h5A, 3);
    // Exact diagonal across the whole range: the tie goes to Y.
    draw_line(0, MaxCoord, MaxCoord, 0, 8'h3C, 2);
    // Decision value exactly zero on a rising and on a falling line.
    draw_line(0, 0, 2, 1, 8'h01, 2);
    draw_line(0, 1, 2, 0, 8'h80, 2);
    // Vertical line given top to bottom.
    draw_line(MaxCoord, 3, MaxCoord, 0, 8'hFE, 3);
    wait_drained();

    while (items_counted < ItemTarget) begin
      sender_calm = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 85) begin
        r = $urandom_range(0, 99);
        if (r < 90) len = $urandom_range(0, 15);
        else if (r < 98) len = $urandom_range(16, 100);
        else len = $urandom_range(101, 300);
        dmin = ($urandom_range(0, 5) == 0) ? len : $urandom_range(0, len);
        if ($urandom_range(0, 1)) begin
          da = len; db = dmin;
        end else begin
          da = dmin; db = len;
        end
        sx = pick_coord();
        sy = pick_coord();
        ex = clamp_coord($urandom_range(0, 1) ? sx + da : sx - da);
        ey = clamp_coord($urandom_range(0, 1) ? sy + db : sy - db);
        nsteps = abs_int(ex - sx);
        if (abs_int(ey - sy) > nsteps) nsteps = abs_int(ey - sy);
        r = $urandom_range(0, 99);
        if (r < 12) nsteps = $urandom_range(0, nsteps);
        else if (r < 20) nsteps = nsteps + $urandom_range(1, 3);
        draw_line(sx, sy, ex, ey, blr_pkg::InkW'($urandom), nsteps);
      end else begin
        // Noise: arbitrary requests over the whole field range.
        repeat ($urandom_range(1, 4)) begin
          send_request(blr_pkg::mode_e'($urandom_range(0, 1)), CW'($urandom),
                       CW'($urandom), CW'($urandom), CW'($urandom),
                       blr_pkg::InkW'($urandom));
        end
      end
      if (!paused && items_counted >= 700) begin
        wait_drained();
        paused = 1;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (lines.mismatches == 0 && lines.owed() == 0) begin
      $display("PASS bresenham_line_rasterizer_core");
    end else begin
      $display("FAIL bresenham_line_rasterizer_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/blr_pkg.sv
hw/rtl/blr_setup.sv
hw/rtl/blr_step.sv
hw/rtl/bresenham_line_rasterizer_core.sv
tb/tb.sv
